// ----- hw/rtl/crsf_pkg.sv -----
`timescale 1ns / 1ps

package crsf_pkg;

    localparam int NUM_CHANNELS  = 16;
    localparam int CH_BITS       = 11;
    localparam int CH_IDX_W      = 4;
    localparam int CH_ADDR_W     = 5;
    localparam int CH_FIRST_BYTE = 3;
    localparam int ACC_W         = 18;
    localparam int NBITS_W       = 5;
    localparam int LEN_W         = 9;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE = 2'd3;

    localparam logic [7:0]  RST_CRC_POLY   = 8'hD5;
    localparam logic [15:0] RST_GAP_TICKS  = 16'd300;
    localparam logic [7:0]  RST_DEV_ADDR   = 8'd200;
    localparam logic [7:0]  RST_FRAME_TYPE = 8'd22;
    localparam logic [15:0] IDLE_MAX       = 16'hFFFF;

    localparam int HDR_ADDR_POS = 0;
    localparam int HDR_LEN_POS  = 1;
    localparam int HDR_TYPE_POS = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_TYPE,
        ST_CHECK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                 rd_en;
        logic [CH_ADDR_W-1:0] rd_addr;
        logic                 busy;
    } t_unp_req;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc,
                                               input logic [7:0] data,
                                               input logic [7:0] poly);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/crsf_ram.sv -----
`timescale 1ns / 1ps

module crsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/crsf_unpack.sv -----
`timescale 1ns / 1ps

module crsf_unpack
    import crsf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [7:0]          i_rd_data,
    output t_unp_req            o_req,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [CH_IDX_W-1:0] o_channel_index,
    output logic [CH_BITS-1:0]  o_channel_value,
    output logic                o_last_channel
);

    logic                 r_busy, n_busy;
    logic                 r_pend, n_pend;
    logic [ACC_W-1:0]     r_acc, n_acc;
    logic [NBITS_W-1:0]   r_nbits, n_nbits;
    logic [CH_ADDR_W-1:0] r_addr, n_addr;
    logic [CH_IDX_W-1:0]  r_ch, n_ch;
    logic                 r_out_valid, n_out_valid;
    logic [CH_IDX_W-1:0]  r_out_index, n_out_index;
    logic [CH_BITS-1:0]   r_out_value, n_out_value;
    logic                 r_out_last, n_out_last;
    logic                 out_free;
    logic                 rd_en;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_busy      = r_busy;
        n_pend      = r_pend;
        n_acc       = r_acc;
        n_nbits     = r_nbits;
        n_addr      = r_addr;
        n_ch        = r_ch;
        n_out_valid = r_out_valid;
        n_out_index = r_out_index;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        rd_en       = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_start) begin
            n_busy  = 1'b1;
            n_pend  = 1'b0;
            n_acc   = '0;
            n_nbits = '0;
            n_addr  = CH_ADDR_W'(CH_FIRST_BYTE);
            n_ch    = '0;
        end else if (r_busy) begin
            if (r_pend) begin
                n_acc   = r_acc | (ACC_W'(i_rd_data) << r_nbits);
                n_nbits = r_nbits + NBITS_W'(8);
                n_pend  = 1'b0;
            end else if (r_nbits >= NBITS_W'(CH_BITS)) begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_index = r_ch;
                    n_out_value = r_acc[CH_BITS-1:0];
                    n_out_last  = (r_ch == CH_IDX_W'(NUM_CHANNELS - 1));
                    n_acc       = r_acc >> CH_BITS;
                    n_nbits     = r_nbits - NBITS_W'(CH_BITS);
                    n_ch        = r_ch + CH_IDX_W'(1);
                    if (r_ch == CH_IDX_W'(NUM_CHANNELS - 1)) begin
                        n_busy = 1'b0;
                    end
                end
            end else begin
                rd_en  = 1'b1;
                n_pend = 1'b1;
                n_addr = r_addr + CH_ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_acc       <= n_acc;
        r_nbits     <= n_nbits;
        r_addr      <= n_addr;
        r_ch        <= n_ch;
        r_out_index <= n_out_index;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_req.rd_en     = rd_en;
    assign o_req.rd_addr   = r_addr;
    assign o_req.busy      = r_busy;
    assign o_out_valid     = r_out_valid;
    assign o_channel_index = r_out_index;
    assign o_channel_value = r_out_value;
    assign o_last_channel  = r_out_last;

endmodule

// ----- hw/rtl/crsf_rc_frame_receiver.sv -----
`timescale 1ns / 1ps
// Input stall: the final byte of a frame with a good CRC holds the input through the
// header reads and the unpacking of 16 channels when address and type match.
// Throughput: one input beat per cycle outside frame ends; channels are bounded by the
// single read port of the frame store (2 header and 22 channel byte reads per frame).
// Reset: synchronous, active low; control state and configuration return to defaults,
// store entries read as zero until written (per-entry valid bits), no clearing pass.

module crsf_rc_frame_receiver
    import crsf_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_cmd,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CH_IDX_W-1:0]   o_channel_index,
    output logic [CH_BITS-1:0]    o_channel_value,
    output logic                  o_last_channel,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);

    t_state               r_state, n_state;
    logic [PW-1:0]        r_pos, n_pos;
    logic [7:0]           r_len, n_len;
    logic [7:0]           r_crc, n_crc;
    logic [15:0]          r_idle, n_idle;
    logic                 r_discard, n_discard;
    logic                 r_addr_ok, n_addr_ok;
    logic [MAX_FRAME_BYTES-1:0] r_valid;
    logic                 r_rd_vld;

    logic [7:0]           r_crc_poly;
    logic [15:0]          r_gap_ticks;
    logic [7:0]           r_dev_addr;
    logic [7:0]           r_frame_type;

    logic                 in_acc;
    logic [LEN_W-1:0]     pos_ext;
    logic [LEN_W-1:0]     end_pos;
    logic [15:0]          idle_inc;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [7:0]           ram_q;
    logic [7:0]           rd_byte;
    logic                 unp_start;
    t_unp_req             unp_req;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign pos_ext  = LEN_W'(r_pos);
    assign end_pos  = LEN_W'(r_len) + LEN_W'(1);
    assign idle_inc = (r_idle == IDLE_MAX) ? r_idle : r_idle + 16'd1;
    assign rd_byte  = r_rd_vld ? ram_q : 8'd0;
    assign ram_waddr = r_pos[AW-1:0];

    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_len     = r_len;
        n_crc     = r_crc;
        n_idle    = r_idle;
        n_discard = r_discard;
        n_addr_ok = r_addr_ok;
        ram_we    = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        unp_start = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_cmd) begin
                        n_idle = idle_inc;
                        if (idle_inc > r_gap_ticks) begin
                            n_pos     = '0;
                            n_crc     = '0;
                            n_discard = 1'b0;
                        end
                    end else begin
                        n_idle = '0;
                        if (!r_discard) begin
                            if (pos_ext >= LEN_W'(MAX_FRAME_BYTES)) begin
                                n_pos     = '0;
                                n_crc     = '0;
                                n_discard = 1'b1;
                            end else if (r_pos == PW'(HDR_LEN_POS)) begin
                                n_len = i_rx_byte;
                                if (i_rx_byte < 8'd2 ||
                                    LEN_W'(i_rx_byte) + LEN_W'(2) > LEN_W'(MAX_FRAME_BYTES)) begin
                                    n_pos     = '0;
                                    n_crc     = '0;
                                    n_discard = 1'b1;
                                end else begin
                                    ram_we = 1'b1;
                                    n_pos  = r_pos + PW'(1);
                                end
                            end else if (pos_ext >= LEN_W'(HDR_TYPE_POS) && pos_ext == end_pos) begin
                                ram_we = 1'b1;
                                n_pos  = '0;
                                n_crc  = '0;
                                if (r_crc != i_rx_byte) begin
                                    n_discard = 1'b1;
                                end else begin
                                    n_state = ST_RD_ADDR;
                                end
                            end else begin
                                ram_we = 1'b1;
                                if (pos_ext >= LEN_W'(HDR_TYPE_POS)) begin
                                    n_crc = crc8_update(r_crc, i_rx_byte, r_crc_poly);
                                end
                                n_pos = r_pos + PW'(1);
                            end
                        end
                    end
                end
            end
            ST_RD_ADDR: begin
                rd_en   = 1'b1;
                rd_addr = AW'(HDR_ADDR_POS);
                n_state = ST_RD_TYPE;
            end
            ST_RD_TYPE: begin
                n_addr_ok = (rd_byte == r_dev_addr);
                rd_en     = 1'b1;
                rd_addr   = AW'(HDR_TYPE_POS);
                n_state   = ST_CHECK;
            end
            ST_CHECK: begin
                if (r_addr_ok && rd_byte == r_frame_type) begin
                    unp_start = 1'b1;
                    n_state   = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                rd_en   = unp_req.rd_en;
                rd_addr = AW'(unp_req.rd_addr);
                if (!unp_req.busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pos        <= '0;
            r_len        <= '0;
            r_crc        <= '0;
            r_idle       <= '0;
            r_discard    <= 1'b0;
            r_addr_ok    <= 1'b0;
            r_valid      <= '0;
            r_rd_vld     <= 1'b0;
            r_crc_poly   <= RST_CRC_POLY;
            r_gap_ticks  <= RST_GAP_TICKS;
            r_dev_addr   <= RST_DEV_ADDR;
            r_frame_type <= RST_FRAME_TYPE;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_crc     <= n_crc;
            r_idle    <= n_idle;
            r_discard <= n_discard;
            r_addr_ok <= n_addr_ok;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_valid[rd_addr];
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CRC_POLY:   r_crc_poly   <= i_cfg_data[7:0];
                    CFG_GAP_TICKS:  r_gap_ticks  <= i_cfg_data;
                    CFG_DEV_ADDR:   r_dev_addr   <= i_cfg_data[7:0];
                    CFG_FRAME_TYPE: r_frame_type <= i_cfg_data[7:0];
                endcase
            end
        end
    end

    crsf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FRAME_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_rx_byte),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    crsf_unpack u_unpack (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (unp_start),
        .i_rd_data       (rd_byte),
        .o_req           (unp_req),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_last_channel  (o_last_channel)
    );

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ----- verif/tb_crsf_rc_frame_receiver.sv -----
`timescale 1ns / 1ps

module tb_crsf_rc_frame_receiver;
    import crsf_pkg::*;

    localparam int   STORE_BYTES   = 64;
    localparam logic CMD_BYTE      = 1'b0;
    localparam logic CMD_TICK      = 1'b1;
    localparam int   SETTLE_CYCLES = 120;
    localparam int   QUIET_LIMIT   = 4000;

    typedef struct packed {
        logic [CH_IDX_W-1:0] index;
        logic [CH_BITS-1:0]  value;
        logic                last;
    } channel_t;

    class rc_frame_tracker;
        logic [7:0]  poly;
        logic [15:0] gap_limit;
        logic [7:0]  dev_addr;
        logic [7:0]  chan_type;
        logic [7:0]  frame_bytes [STORE_BYTES];
        int unsigned wr_pos;
        logic [7:0]  len_byte;
        logic [7:0]  crc;
        logic [15:0] idle;
        bit          discarding;
        channel_t    channels_due [$];
        int unsigned beats_seen;
        int unsigned frames_decoded;
        int unsigned channels_matched;
        int unsigned errors;

        function new();
            poly      = RST_CRC_POLY;
            gap_limit = RST_GAP_TICKS;
            dev_addr  = RST_DEV_ADDR;
            chan_type = RST_FRAME_TYPE;
            foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
            wr_pos           = 0;
            len_byte         = 8'h00;
            crc              = 8'h00;
            idle             = 16'h0000;
            discarding       = 1'b0;
            beats_seen       = 0;
            frames_decoded   = 0;
            channels_matched = 0;
            errors           = 0;
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CRC_POLY:   poly      = data[7:0];
                CFG_GAP_TICKS:  gap_limit = data;
                CFG_DEV_ADDR:   dev_addr  = data[7:0];
                CFG_FRAME_TYPE: chan_type = data[7:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] crc_step(logic [7:0] c, logic [7:0] b);
            logic [7:0] r;
            r = c ^ b;
            for (int i = 0; i < 8; i++) begin
                r = r[7] ? ((r << 1) ^ poly) : (r << 1);
            end
            return r;
        endfunction

        function void restart();
            wr_pos = 0;
            crc    = 8'h00;
        endfunction

        function void queue_channels();
            int unsigned bitpos;
            int unsigned at;
            logic [23:0] word;
            channel_t    ch;
            frames_decoded++;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                bitpos   = k * CH_BITS;
                at       = CH_FIRST_BYTE + bitpos / 8;
                word     = {frame_bytes[at+2], frame_bytes[at+1], frame_bytes[at]};
                ch.index = CH_IDX_W'(k);
                ch.value = CH_BITS'(word >> (bitpos % 8));
                ch.last  = (k == NUM_CHANNELS - 1);
                channels_due.push_back(ch);
            end
        endfunction

        function void note_beat(logic kind, logic [7:0] b);
            int unsigned p;
            beats_seen++;
            if (kind == CMD_TICK) begin
                if (idle != IDLE_MAX) idle++;
                if (idle > gap_limit) begin
                    restart();
                    discarding = 1'b0;
                end
                return;
            end
            idle = 16'h0000;
            if (discarding) return;
            p = wr_pos;
            if (p >= STORE_BYTES) begin
                restart();
                discarding = 1'b1;
                return;
            end
            if (p == 1) begin
                len_byte = b;
                if (b < 2 || int'(b) + 2 > STORE_BYTES) begin
                    restart();
                    discarding = 1'b1;
                    return;
                end
            end
            if (p >= 2 && p == int'(len_byte) + 1) begin
                frame_bytes[p] = b;
                if (crc != b) begin
                    restart();
                    discarding = 1'b1;
                    return;
                end
                restart();
                if (frame_bytes[0] == dev_addr && frame_bytes[2] == chan_type) queue_channels();
                return;
            end
            frame_bytes[p] = b;
            if (p >= 2) crc = crc_step(crc, b);
            wr_pos = p + 1;
        endfunction

        function void check_channel(channel_t got);
            channel_t want;
            if (channels_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected channel: index %0d value %0d last %0d",
                         $time, got.index, got.value, got.last);
                return;
            end
            want = channels_due.pop_front();
            if (got.index !== want.index || got.value !== want.value ||
                got.last !== want.last) begin
                errors++;
                $display("%0t: expected index %0d value %0d last %0d, %s",
                         $time, want.index, want.value, want.last, "got");
                $display("%0t: got index %0d value %0d last %0d",
                         $time, got.index, got.value, got.last);
            end else begin
                channels_matched++;
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic                  cmd       = CMD_BYTE;
    logic [7:0]            rx_byte   = 8'h00;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [CH_IDX_W-1:0]   channel_index;
    logic [CH_BITS-1:0]    channel_value;
    logic                  last_channel;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_CRC_POLY;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    rc_frame_tracker sb;
    bit              in_burst     = 1'b0;
    int unsigned     settings     = 1;
    int unsigned     quiet_cycles = 0;

    crsf_rc_frame_receiver dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_cmd           (cmd),
        .i_rx_byte       (rx_byte),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_channel_index (channel_index),
        .o_channel_value (channel_value),
        .o_last_channel  (last_channel),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("crsf_rc_frame_receiver: mismatch");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_beat(input logic kind, input logic [7:0] data);
        int unsigned wait_cycles;
        wait_cycles = in_burst ? 0 : $urandom_range(0, 9);
        if (wait_cycles != 0) begin
            in_valid <= 1'b0;
            repeat (wait_cycles) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= kind;
        rx_byte  <= data;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_beat(kind, data);
        @(negedge clk);
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++) send_beat(CMD_TICK, rand_byte());
    endtask

    task automatic recover();
        send_ticks(int'(sb.gap_limit) + 1);
    endtask

    // cut: position at which the frame is abandoned, -1 for a complete frame
    task automatic send_frame(input logic [7:0] addr, input int len, input logic [7:0] ftype,
                              input bit bad_crc, input int cut);
        logic [7:0] c;
        logic [7:0] b;
        int         span;
        c = 8'h00;
        send_beat(CMD_BYTE, addr);
        send_beat(CMD_BYTE, 8'(len));
        for (int i = 2; i <= len; i++) begin
            if (i == cut) return;
            b = (i == 2) ? ftype : rand_byte();
            c = sb.crc_step(c, b);
            send_beat(CMD_BYTE, b);
            if (sb.gap_limit <= 12 && $urandom_range(0, 11) == 0) begin
                span = (sb.gap_limit < 3) ? int'(sb.gap_limit) : 3;
                send_ticks($urandom_range(1, span));
            end
        end
        send_beat(CMD_BYTE, bad_crc ? (c ^ (8'h01 << $urandom_range(0, 7))) : c);
    endtask

    task automatic settle(input int tail);
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.channels_due.size() != 0) @(negedge clk);
        repeat (tail) @(negedge clk);
    endtask

    task automatic write_regs(input logic [7:0] poly, input logic [15:0] gap,
                              input logic [7:0] addr, input logic [7:0] ftype);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CRC_POLY;
        cfg_data  <= {8'h00, poly};
        @(negedge clk);
        cfg_index <= CFG_GAP_TICKS;
        cfg_data  <= gap;
        @(negedge clk);
        cfg_index <= CFG_DEV_ADDR;
        cfg_data  <= {8'h00, addr};
        @(negedge clk);
        cfg_index <= CFG_FRAME_TYPE;
        cfg_data  <= {8'h00, ftype};
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_config(CFG_CRC_POLY, {8'h00, poly});
        sb.set_config(CFG_GAP_TICKS, gap);
        sb.set_config(CFG_DEV_ADDR, {8'h00, addr});
        sb.set_config(CFG_FRAME_TYPE, {8'h00, ftype});
        settings++;
    endtask

    task automatic random_phase(input int unsigned beats);
        int unsigned stop_at;
        int unsigned pick;
        int          len;
        int          cut;
        logic [7:0]  addr;
        logic [7:0]  ftype;
        logic [7:0]  bad_len;
        bit          bad;
        stop_at = sb.beats_seen + beats;
        if (sb.gap_limit <= 300) recover();
        while (sb.beats_seen < stop_at) begin
            in_burst = ($urandom_range(0, 4) == 0);
            pick     = $urandom_range(0, 99);
            if (pick < 65) begin
                pick = $urandom_range(0, 99);
                if (pick < 35) len = 24;
                else if (pick < 75) len = $urandom_range(2, 10);
                else if (pick < 95) len = $urandom_range(11, 61);
                else len = 62;
                addr  = ($urandom_range(0, 6) == 0) ? rand_byte() : sb.dev_addr;
                ftype = ($urandom_range(0, 6) == 0) ? rand_byte() : sb.chan_type;
                bad   = ($urandom_range(0, 9) == 0);
                cut   = ($urandom_range(0, 19) == 0) ? $urandom_range(2, len) : -1;
                send_frame(addr, len, ftype, bad, cut);
            end else if (pick < 75) begin
                bad_len = $urandom_range(0, 1) ? 8'($urandom_range(0, 1))
                                               : 8'($urandom_range(63, 255));
                send_beat(CMD_BYTE, rand_byte());
                send_beat(CMD_BYTE, bad_len);
                send_beat(CMD_BYTE, rand_byte());
            end else if (pick < 87) begin
                repeat ($urandom_range(1, 4)) send_beat(CMD_BYTE, rand_byte());
            end else begin
                send_ticks($urandom_range(1, 12));
            end
            if ((sb.discarding || sb.wr_pos != 0) && sb.gap_limit <= 300
                && $urandom_range(0, 9) != 0) recover();
            if ($urandom_range(0, 24) == 0) settle(0);
        end
        in_burst = 1'b0;
    endtask

    initial begin : drain_channels
        int unsigned hold;
        channel_t    got;
        bit          out_burst;
        out_burst = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            hold = out_burst ? 0 : $urandom_range(0, 9);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            got.index = channel_index;
            got.value = channel_value;
            got.last  = last_channel;
            sb.check_channel(got);
            if ($urandom_range(0, 15) == 0) out_burst = !out_burst;
            @(negedge clk);
        end
    end

    initial begin : run
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // shortest frame under reset settings: channels come mostly from zeroed store
        send_frame(RST_DEV_ADDR, 2, RST_FRAME_TYPE, 1'b0, -1);
        settle(SETTLE_CYCLES);
        write_regs(RST_CRC_POLY, 16'd2, RST_DEV_ADDR, RST_FRAME_TYPE);
        send_beat(CMD_BYTE, RST_DEV_ADDR);
        send_beat(CMD_BYTE, 8'd1);
        send_beat(CMD_BYTE, 8'hFF);
        send_ticks(3);
        send_beat(CMD_BYTE, 8'h00);
        send_beat(CMD_BYTE, 8'd63);
        send_ticks(3);
        send_frame(8'h00, 2, RST_FRAME_TYPE, 1'b0, -1);
        send_frame(RST_DEV_ADDR, 2, 8'hFF, 1'b0, -1);
        send_frame(RST_DEV_ADDR, 2, RST_FRAME_TYPE, 1'b1, -1);
        send_ticks(3);
        send_beat(CMD_BYTE, RST_DEV_ADDR);
        send_beat(CMD_BYTE, 8'd24);
        send_ticks(3);

        settle(SETTLE_CYCLES);
        write_regs(RST_CRC_POLY, 16'd3, RST_DEV_ADDR, RST_FRAME_TYPE);
        random_phase(60);
        settle(SETTLE_CYCLES);
        write_regs(8'h00, 16'd1, 8'h00, 8'h00);
        random_phase(60);
        settle(SETTLE_CYCLES);
        write_regs(8'hFF, 16'd12, 8'hFF, 8'hFF);
        random_phase(60);
        settle(SETTLE_CYCLES);
        write_regs(8'h07, 16'hFFFF, 8'h5A, 8'hA5);
        random_phase(30);
        settle(SETTLE_CYCLES);
        write_regs(rand_byte(), 16'($urandom_range(1, 8)), rand_byte(), rand_byte());
        random_phase(60);
        settle(SETTLE_CYCLES);
        write_regs(RST_CRC_POLY, 16'd2, RST_DEV_ADDR, RST_FRAME_TYPE);
        random_phase(60);

        settle(SETTLE_CYCLES);
        $display("Run: %0d byte and tick beats under %0d register settings, %0d frames decoded.",
                 sb.beats_seen, settings, sb.frames_decoded);
        $display("Channels: %0d matched, %0d errors.", sb.channels_matched, sb.errors);
        if (sb.errors == 0) begin
            $display("crsf_rc_frame_receiver: match");
        end else begin
            $display("crsf_rc_frame_receiver: mismatch");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/crsf_pkg.sv
hw/rtl/crsf_ram.sv
hw/rtl/crsf_unpack.sv
hw/rtl/crsf_rc_frame_receiver.sv
verif/tb_crsf_rc_frame_receiver.sv
